/* rtl/szdt_pkg.sv */
// Shared types and constants for the scroll zoom debt tracker.
package szdt_pkg;

  localparam int unsigned CntW   = 16;
  localparam int unsigned QuietW = 32;
  localparam int unsigned TimeW  = 64;
  localparam int unsigned WheelW = 32;
  localparam int unsigned CfgW   = 32;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  typedef enum logic [1:0] {
    MODE_WHEEL        = 2'd0,
    MODE_TICK         = 2'd1,
    MODE_CLEAR_KEEP   = 2'd2,
    MODE_CLEAR_FORGET = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    DIR_UNKNOWN = 2'd0,
    DIR_POS     = 2'd1,
    DIR_NEG     = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    CFG_DEBT_CAP       = 2'd0,
    CFG_EXIT_THRESHOLD = 2'd1,
    CFG_QUIET_TIME     = 2'd2
  } cfg_idx_e;

  localparam logic [CntW-1:0]   DebtCapRst   = 16'hFFFF;
  localparam logic [CntW-1:0]   ExitThrRst   = 16'd1;
  localparam logic [QuietW-1:0] QuietTimeRst = 32'd500000;

  typedef struct packed {
    logic [CntW-1:0]   debt_cap;
    logic [CntW-1:0]   exit_threshold;
    logic [QuietW-1:0] quiet_time_us;
  } cfg_t;

  typedef struct packed {
    logic             active;
    logic             armed;
    logic [TimeW-1:0] due_us;
    logic [CntW-1:0]  debt;
    logic [CntW-1:0]  overscroll;
    dir_e             zoom_in_dir;
  } state_t;

endpackage

/* rtl/szdt_if.sv */
// Valid/ready channel interfaces for events in and results out.
interface szdt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic signed [31:0] wheel;
  logic [63:0] now_us;

  modport source (output valid, output mode, output wheel, output now_us, input ready);
  modport sink   (input valid, input mode, input wheel, input now_us, output ready);
endinterface

interface szdt_out_if;
  logic valid;
  logic ready;
  logic handled;
  logic zoom_active;
  logic exit_armed;

  modport source (output valid, output handled, output zoom_active, output exit_armed,
                  input ready);
  modport sink   (input valid, input handled, input zoom_active, input exit_armed,
                  output ready);
endinterface

/* rtl/szdt_step.sv */
// Next-state logic for one tracker event: wheel, tick or clear.
module szdt_step (
  input  szdt_pkg::state_t          state_i,
  input  szdt_pkg::cfg_t            cfg_i,
  input  logic [1:0]                mode_i,
  input  logic [szdt_pkg::WheelW-1:0] wheel_i,
  input  logic [szdt_pkg::TimeW-1:0]  now_i,
  output szdt_pkg::state_t          state_o,
  output logic                      handled_o
);

  always_comb begin
    logic                         neg;
    logic [szdt_pkg::WheelW-1:0]  mag;
    logic [szdt_pkg::WheelW-1:0]  rem;
    szdt_pkg::dir_e               dir;
    szdt_pkg::dir_e               eff_dir;
    logic [szdt_pkg::WheelW:0]    debt_sum;
    logic [szdt_pkg::WheelW:0]    over_sum;
    logic [szdt_pkg::CntW-1:0]    debt_sat;
    logic [szdt_pkg::CntW-1:0]    over_sat;
    logic [szdt_pkg::TimeW-1:0]   deadline;
    logic                         changed;

    neg      = wheel_i[szdt_pkg::WheelW-1];
    mag      = neg ? (~wheel_i + 32'd1) : wheel_i;
    dir      = neg ? szdt_pkg::DIR_NEG : szdt_pkg::DIR_POS;
    eff_dir  = (state_i.zoom_in_dir == szdt_pkg::DIR_UNKNOWN) ? dir : state_i.zoom_in_dir;

    // Saturating debt add; a debt above a lowered cap snaps to the cap
    debt_sum = {17'd0, state_i.debt} + {1'b0, mag};
    debt_sat = (debt_sum >= {17'd0, cfg_i.debt_cap}) ? cfg_i.debt_cap
                                                    : debt_sum[szdt_pkg::CntW-1:0];

    rem      = mag - {16'd0, state_i.debt};
    over_sum = {17'd0, state_i.overscroll} + {1'b0, rem};
    over_sat = (over_sum >= {17'd0, szdt_pkg::CntMax}) ? szdt_pkg::CntMax
                                                      : over_sum[szdt_pkg::CntW-1:0];

    deadline = now_i + {32'd0, cfg_i.quiet_time_us};

    changed  = state_i.active || state_i.armed || (state_i.debt != '0) ||
               (state_i.overscroll != '0);

    state_o   = state_i;
    handled_o = 1'b0;

    case (szdt_pkg::mode_e'(mode_i))
      szdt_pkg::MODE_WHEEL: begin
        if (wheel_i != '0) begin
          state_o.armed       = 1'b0;
          state_o.due_us      = '0;
          state_o.zoom_in_dir = eff_dir;
          if (dir == eff_dir) begin
            state_o.debt       = debt_sat;
            state_o.overscroll = '0;
            state_o.active     = 1'b1;
            handled_o          = 1'b1;
          end else if (state_i.active) begin
            handled_o = 1'b1;
            if (mag < {16'd0, state_i.debt}) begin
              state_o.debt       = state_i.debt - mag[szdt_pkg::CntW-1:0];
              state_o.overscroll = '0;
            end else begin
              state_o.debt       = '0;
              state_o.overscroll = over_sat;
              if (over_sat >= cfg_i.exit_threshold) begin
                state_o.armed  = 1'b1;
                state_o.due_us = deadline;
              end
            end
          end
        end
      end
      szdt_pkg::MODE_TICK: begin
        if (state_i.active && state_i.armed && !(now_i < state_i.due_us)) begin
          state_o.active     = 1'b0;
          state_o.armed      = 1'b0;
          state_o.due_us     = '0;
          state_o.debt       = '0;
          state_o.overscroll = '0;
          handled_o          = 1'b1;
        end
      end
      szdt_pkg::MODE_CLEAR_KEEP, szdt_pkg::MODE_CLEAR_FORGET: begin
        state_o.active     = 1'b0;
        state_o.armed      = 1'b0;
        state_o.due_us     = '0;
        state_o.debt       = '0;
        state_o.overscroll = '0;
        handled_o          = changed;
        if (mode_i == szdt_pkg::MODE_CLEAR_FORGET) begin
          state_o.zoom_in_dir = szdt_pkg::DIR_UNKNOWN;
          handled_o = changed || (state_i.zoom_in_dir != szdt_pkg::DIR_UNKNOWN);
        end
      end
      default: begin
        state_o   = state_i;
        handled_o = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/scroll_zoom_debt_tracker.sv */
// Top level of the scroll zoom debt tracker: input stage, state, result register.
//
//   channel  dir  payload                         accepted when
//   in_i     in   mode, wheel, now_us             in_i.valid && in_i.ready
//   out_o    out  handled, zoom_active, exit_armed out_o.valid && out_o.ready
//   cfg      in   cfg_idx_i, cfg_data_i           cfg_we_i
//
// One item per cycle while out_o does not stall; items pass the input register, then the result register.
// Tracker state commits when an item moves from the input register to the result register.
// A stall on out_o holds both stages; in_i.ready drops only when both are full.
// Reset clears tracker state and loads the default debt cap, threshold and quiet time.
module scroll_zoom_debt_tracker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [szdt_pkg::CfgW-1:0] cfg_data_i,
  szdt_in_if.sink                   in_i,
  szdt_out_if.source                out_o
);

  szdt_pkg::cfg_t   cfg_q;
  szdt_pkg::state_t state_q;
  szdt_pkg::state_t state_d;

  logic                         s1_valid_q;
  logic [1:0]                   mode_q;
  logic [szdt_pkg::WheelW-1:0]  wheel_q;
  logic [szdt_pkg::TimeW-1:0]   now_q;

  logic out_valid_q;
  logic handled_q;
  logic active_q;
  logic armed_q;
  logic handled_d;
  logic advance;

  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;

  szdt_step u_step (
    .state_i   (state_q),
    .cfg_i     (cfg_q),
    .mode_i    (mode_q),
    .wheel_i   (wheel_q),
    .now_i     (now_q),
    .state_o   (state_d),
    .handled_o (handled_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debt_cap       <= szdt_pkg::DebtCapRst;
      cfg_q.exit_threshold <= szdt_pkg::ExitThrRst;
      cfg_q.quiet_time_us  <= szdt_pkg::QuietTimeRst;
    end else if (cfg_we_i) begin
      case (szdt_pkg::cfg_idx_e'(cfg_idx_i))
        szdt_pkg::CFG_DEBT_CAP:       cfg_q.debt_cap       <= cfg_data_i[szdt_pkg::CntW-1:0];
        szdt_pkg::CFG_EXIT_THRESHOLD: cfg_q.exit_threshold <= cfg_data_i[szdt_pkg::CntW-1:0];
        szdt_pkg::CFG_QUIET_TIME:     cfg_q.quiet_time_us  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{active: 1'b0, armed: 1'b0, due_us: '0, debt: '0,
                   overscroll: '0, zoom_in_dir: szdt_pkg::DIR_UNKNOWN};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      mode_q  <= in_i.mode;
      wheel_q <= in_i.wheel;
      now_q   <= in_i.now_us;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      handled_q <= handled_d;
      active_q  <= state_d.active;
      armed_q   <= state_d.armed;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.handled     = handled_q;
  assign out_o.zoom_active = active_q;
  assign out_o.exit_armed  = armed_q;

endmodule

/* verif/scroll_zoom_debt_tracker_tb.sv */
// Self-checking testbench for the scroll zoom debt tracker: directed table plus random phases.
module scroll_zoom_debt_tracker_tb;
  import szdt_pkg::*;

  localparam int unsigned NumRows      = 30;
  localparam int unsigned NumPhases    = 10;
  localparam int unsigned PhaseItems   = 122;
  localparam int unsigned HoldCycles   = 200;
  localparam int unsigned StallLimit   = 5000;
  localparam int unsigned DrainCycles  = 4;
  localparam logic [1:0]  CfgIdxUnused = 2'd3;

  typedef struct packed {
    logic handled;
    logic zoom_active;
    logic exit_armed;
  } zoom_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [1:0]        cfg_idx;
    logic [CfgW-1:0]   cfg_data;
    mode_e             mode;
    logic [WheelW-1:0] wheel;
    logic [TimeW-1:0]  now_us;
    logic              typed;
    zoom_result_t      result;
  } dir_row_t;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            cfg_we;
  logic [1:0]      cfg_idx;
  logic [CfgW-1:0] cfg_data;

  szdt_in_if  in_if ();
  szdt_out_if out_if ();

  scroll_zoom_debt_tracker u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Tracker copy used for prediction
  state_t       trk;
  cfg_t         trk_cfg;
  zoom_result_t zoom_results_due [$];

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_req       = 0;
  int unsigned idle_cycles    = 0;
  int unsigned n_items        = 0;
  int unsigned n_directed     = 0;
  int unsigned n_results      = 0;
  int unsigned n_errors       = 0;
  int unsigned n_cfg_writes   = 0;
  int unsigned n_arms         = 0;
  int unsigned n_exits        = 0;
  logic [TimeW-1:0] now_base  = '0;

  // kind, reg, data, mode, wheel, now, typed, {handled, zoom_active, exit_armed}
  dir_row_t dir_rows [NumRows] = '{
    '{ROW_ITEM, 2'd0, 32'd0, MODE_TICK,         32'd0,          64'd0,      1'b1, 3'b000},
    '{ROW_ITEM, 2'd0, 32'd0, MODE_CLEAR_FORGET, 32'd0,          64'd0,      1'b1, 3'b000},
    '{ROW_ITEM, 2'd0, 32'd0, MODE_WHEEL,        32'd0,          64'd10,     1'b1, 3'b000},
    '{ROW_ITEM, 2'd0, 32'd0, MODE_WHEEL,        32'd5,          64'd20,     1'b1, 3'b110},
    '{ROW_ITEM, 2'd0, 32'd0, MODE_WHEEL,        32'h7FFF_FFFF,  64'd30,     1'b1, 3'b110},
    '{ROW_ITEM, 2'd0, 32'd0, MODE_WHEEL,        32'h8000_0000,  64'd1000,   1'b1, 3'b111},
    // one short of the deadline, then exactly on it
    '{ROW_ITEM, 2'd0, 32'd0, MODE_TICK,         32'd0,          64'd500999, 1'b1, 3'b011},
    '{ROW_ITEM, 2'd0, 32'd0, MODE_TICK,         32'd0,          64'd501000, 1'b1, 3'b100},
    // wrong way while inactive
    '{ROW_ITEM, 2'd0, 32'd0, MODE_WHEEL,        -32'sd3,        64'd501010, 1'b1, 3'b000},
    '{ROW_ITEM, 2'd0, 32'd0, MODE_CLEAR_FORGET, 32'd0,          64'd0,      1'b1, 3'b100},
    '{ROW_ITEM, 2'd0, 32'd0, MODE_WHEEL,        -32'sd7,        64'd502000, 1'b1, 3'b110},
    '{ROW_ITEM, 2'd0, 32'd0, MODE_WHEEL,        32'd3,          64'd502010, 1'b0, 3'b000},
    '{ROW_ITEM, 2'd0, 32'd0, MODE_WHEEL,        32'd4,          64'd502020, 1'b0, 3'b000},
    '{ROW_ITEM, 2'd0, 32'd0, MODE_WHEEL,        32'd1,          64'd600000, 1'b1, 3'b111},
    '{ROW_ITEM, 2'd0, 32'd0, MODE_WHEEL,        32'd0,          64'd600010, 1'b1, 3'b011},
    '{ROW_ITEM, 2'd0, 32'd0, MODE_WHEEL,        -32'sd2,        64'd600020, 1'b1, 3'b110},
    // deadline wraps past 2^64
    '{ROW_ITEM, 2'd0, 32'd0, MODE_WHEEL,        32'd3,          '1,         1'b0, 3'b000},
    '{ROW_ITEM, 2'd0, 32'd0, MODE_TICK,         32'd0,          64'd499998, 1'b1, 3'b011},
    '{ROW_ITEM, 2'd0, 32'd0, MODE_TICK,         32'd0,          64'd499999, 1'b1, 3'b100},
    '{ROW_ITEM, 2'd0, 32'd0, MODE_WHEEL,        -32'sd60000,    64'd10,     1'b1, 3'b110},
    // cap drops below the held debt; upper data bits are junk
    '{ROW_CFG,  CFG_DEBT_CAP, 32'hABCD_0064, MODE_WHEEL, 32'd0, 64'd0, 1'b0, 3'b000},
    '{ROW_ITEM, 2'd0, 32'd0, MODE_WHEEL,        -32'sd1,        64'd20,     1'b1, 3'b110},
    '{ROW_ITEM, 2'd0, 32'd0, MODE_WHEEL,        32'd101,        64'd30,     1'b1, 3'b111},
    '{ROW_CFG,  CFG_DEBT_CAP,       32'd0, MODE_WHEEL, 32'd0, 64'd0, 1'b0, 3'b000},
    '{ROW_CFG,  CFG_EXIT_THRESHOLD, 32'd0, MODE_WHEEL, 32'd0, 64'd0, 1'b0, 3'b000},
    '{ROW_ITEM, 2'd0, 32'd0, MODE_CLEAR_KEEP,   32'd0,          64'd0,      1'b1, 3'b100},
    '{ROW_ITEM, 2'd0, 32'd0, MODE_WHEEL,        -32'sd5,        64'd40,     1'b1, 3'b110},
    '{ROW_ITEM, 2'd0, 32'd0, MODE_WHEEL,        32'd1,          64'd50,     1'b1, 3'b111},
    '{ROW_CFG,  CfgIdxUnused, 32'hFFFF_FFFF, MODE_WHEEL, 32'd0, 64'd0, 1'b0, 3'b000},
    '{ROW_ITEM, 2'd0, 32'd0, MODE_CLEAR_FORGET, 32'd0,          64'd0,      1'b1, 3'b100}
  };

  function automatic logic [CntW-1:0] sat_add(input logic [CntW-1:0] base,
                                              input logic [31:0]     add,
                                              input logic [CntW-1:0] lim);
    if (add >= {16'd0, lim} || {16'd0, base} >= {16'd0, lim} - add) return lim;
    return base + add[CntW-1:0];
  endfunction

  function automatic void drop_gesture();
    trk.active     = 1'b0;
    trk.armed      = 1'b0;
    trk.due_us     = '0;
    trk.debt       = '0;
    trk.overscroll = '0;
  endfunction

  function automatic zoom_result_t zoom_step(input mode_e             m,
                                             input logic [WheelW-1:0] w,
                                             input logic [TimeW-1:0]  t);
    zoom_result_t r;
    dir_e         d;
    logic [31:0]  mag;
    logic         hit;
    hit = 1'b0;
    case (m)
      MODE_WHEEL: begin
        if (w != '0) begin
          d   = w[WheelW-1] ? DIR_NEG : DIR_POS;
          mag = w[WheelW-1] ? -w : w;
          trk.armed  = 1'b0;
          trk.due_us = '0;
          if (trk.zoom_in_dir == DIR_UNKNOWN) trk.zoom_in_dir = d;
          if (d == trk.zoom_in_dir) begin
            trk.debt       = sat_add(trk.debt, mag, trk_cfg.debt_cap);
            trk.overscroll = '0;
            trk.active     = 1'b1;
            hit            = 1'b1;
          end else if (trk.active) begin
            hit = 1'b1;
            if (mag < {16'd0, trk.debt}) begin
              trk.debt       = trk.debt - mag[CntW-1:0];
              trk.overscroll = '0;
            end else begin
              // pay off the debt, the rest is overscroll
              mag            = mag - {16'd0, trk.debt};
              trk.debt       = '0;
              trk.overscroll = sat_add(trk.overscroll, mag, CntMax);
              if (trk.overscroll >= trk_cfg.exit_threshold) begin
                trk.armed  = 1'b1;
                trk.due_us = t + {32'd0, trk_cfg.quiet_time_us};
                n_arms++;
              end
            end
          end
        end
      end
      MODE_TICK: begin
        if (trk.active && trk.armed && t >= trk.due_us) begin
          drop_gesture();
          hit = 1'b1;
          n_exits++;
        end
      end
      default: begin
        hit = trk.active || trk.armed || trk.debt != '0 || trk.overscroll != '0 ||
              (m == MODE_CLEAR_FORGET && trk.zoom_in_dir != DIR_UNKNOWN);
        drop_gesture();
        if (m == MODE_CLEAR_FORGET) trk.zoom_in_dir = DIR_UNKNOWN;
      end
    endcase
    r.handled     = hit;
    r.zoom_active = trk.active;
    r.exit_armed  = trk.armed;
    return r;
  endfunction

  task automatic offer_event(input mode_e             m,
                             input logic [WheelW-1:0] w,
                             input logic [TimeW-1:0]  t,
                             input logic              typed,
                             input zoom_result_t      typed_res);
    zoom_result_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.mode   <= m;
    in_if.wheel  <= w;
    in_if.now_us <= t;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    res = zoom_step(m, w, t);
    zoom_results_due.push_back(typed ? typed_res : res);
    n_items++;
  endtask

  // Sender stops until every expected result is out, then lets the pipe settle
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (zoom_results_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CfgW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_DEBT_CAP:       trk_cfg.debt_cap       = data[CntW-1:0];
      CFG_EXIT_THRESHOLD: trk_cfg.exit_threshold = data[CntW-1:0];
      CFG_QUIET_TIME:     trk_cfg.quiet_time_us  = data[QuietW-1:0];
      default: ;
    endcase
    n_cfg_writes++;
  endtask

  // Mostly gestures: zoom-in scrolls, reverse scrolls sized around debt and
  // threshold, ticks aimed at the deadline; a few clears and pure noise.
  task automatic random_event();
    mode_e             m;
    logic [31:0]       mag;
    logic [31:0]       thr_span;
    logic [WheelW-1:0] w;
    logic [TimeW-1:0]  t;
    logic              neg;
    int unsigned       pick;
    pick     = $urandom_range(99);
    w        = '0;
    thr_span = {16'd0, trk_cfg.exit_threshold} + 32'd1;
    now_base = now_base + $urandom_range(0, 64);
    t        = now_base;
    if (pick < 75) begin
      m = MODE_WHEEL;
      case ($urandom_range(7))
        0:       mag = 32'd1;
        1, 2:    mag = $urandom_range(1, thr_span);
        3:       mag = $urandom_range(1, {16'd0, trk.debt} + thr_span);
        4:       mag = $urandom_range(0, {16'd0, trk_cfg.debt_cap} + 32'd1);
        5:       mag = {16'd0, trk.debt} + $urandom_range(0, 1);
        6:       mag = $urandom();
        default: mag = $urandom_range(1, 16);
      endcase
      // below 40 scroll toward zoom-in, from 40 up the other way
      if (trk.zoom_in_dir == DIR_UNKNOWN) neg = 1'($urandom_range(1));
      else neg = (trk.zoom_in_dir == DIR_NEG) ^ (pick >= 40);
      w = neg ? -mag : mag;
    end else if (pick < 88) begin
      m = MODE_TICK;
      if (trk.armed && $urandom_range(1) == 1)
        t = trk.due_us + 64'($urandom_range(0, 2)) - 64'd1;
      else if ($urandom_range(1) == 1)
        t = now_base + {32'd0, $urandom()};
    end else if (pick < 92) begin
      m = MODE_CLEAR_KEEP;
    end else if (pick < 95) begin
      m = MODE_CLEAR_FORGET;
    end else begin
      m = mode_e'($urandom_range(3));
      w = $urandom();
      t = {$urandom(), $urandom()};
    end
    offer_event(m, w, t, 1'b0, '0);
  endtask

  // Receiver: random stalls, or a long hold-off when asked
  initial begin : sink_ctl
    int unsigned hold_left;
    hold_left    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    zoom_result_t want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        n_results++;
        if (zoom_results_due.size() == 0) begin
          $error("unexpected result: handled %0b zoom_active %0b exit_armed %0b",
                 out_if.handled, out_if.zoom_active, out_if.exit_armed);
          n_errors++;
        end else begin
          want = zoom_results_due.pop_front();
          if (out_if.handled !== want.handled) begin
            $error("handled: expected %0b, actual %0b", want.handled, out_if.handled);
            n_errors++;
          end
          if (out_if.zoom_active !== want.zoom_active) begin
            $error("zoom_active: expected %0b, actual %0b",
                   want.zoom_active, out_if.zoom_active);
            n_errors++;
          end
          if (out_if.exit_armed !== want.exit_armed) begin
            $error("exit_armed: expected %0b, actual %0b",
                   want.exit_armed, out_if.exit_armed);
            n_errors++;
          end
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("Timeout: no item moved for %0d cycles", StallLimit);
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    logic [CntW-1:0]   cap;
    logic [CntW-1:0]   thr;
    logic [QuietW-1:0] quiet;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    in_if.valid  = 1'b0;
    in_if.mode   = MODE_WHEEL;
    in_if.wheel  = '0;
    in_if.now_us = '0;
    trk          = '0;
    trk_cfg      = '{DebtCapRst, ExitThrRst, QuietTimeRst};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_data);
      end else begin
        offer_event(dir_rows[i].mode, dir_rows[i].wheel, dir_rows[i].now_us,
                    dir_rows[i].typed, dir_rows[i].result);
      end
    end
    n_directed = n_items;

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       begin cap = 16'hFFFF; thr = 16'd1;     quiet = 32'd500000;    end
        1:       begin cap = 16'd1;    thr = 16'd1;     quiet = 32'd0;         end
        2:       begin cap = 16'd0;    thr = 16'd0;     quiet = 32'd0;         end
        3:       begin cap = 16'hFFFF; thr = 16'hFFFF;  quiet = 32'hFFFF_FFFF; end
        4:       begin cap = 16'd100;  thr = 16'd10;    quiet = 32'd1000;      end
        5:       begin cap = 16'd16;   thr = 16'd4;     quiet = 32'd50;        end
        6:       begin cap = 16'd300;  thr = 16'hFFFF;  quiet = 32'd20;        end
        7:       begin cap = 16'd2;    thr = 16'd0;     quiet = 32'd5;         end
        default: begin
          cap   = 16'($urandom_range(1, 65535));
          thr   = 16'($urandom_range(1, 64));
          quiet = $urandom_range(0, 100000);
        end
      endcase
      wait_idle();
      write_reg(CFG_DEBT_CAP, {16'($urandom()), cap});
      write_reg(CFG_EXIT_THRESHOLD, {16'($urandom()), thr});
      write_reg(CFG_QUIET_TIME, quiet);
      case (p % 4)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 83; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 83; end
        default: begin src_idle_pct = 22; sink_stall_pct = 22; end
      endcase
      now_base = p[0] ? {$urandom(), $urandom()} : 64'($urandom_range(0, 1000));
      // back up the pipe while items keep coming
      if (p == 0) hold_req = HoldCycles;
      for (int k = 0; k < PhaseItems; k++) random_event();
    end

    wait_idle();
    $display("Covered %0d events (%0d directed) and %0d results over %0d phases",
             n_items, n_directed, n_results, NumPhases);
    $display("Register writes %0d, exits armed %0d, exits taken on tick %0d",
             n_cfg_writes, n_arms, n_exits);
    if (n_errors == 0 && zoom_results_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
